### hdl/tsd_pkg.sv
package tsd_pkg;

   // Input item: one raw byte of the tokenized file
   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   // Result item: one converted character or a status marker
   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
      logic       finished;
      logic [1:0] error;
   } rsp_type;

   // Parser phases
   typedef enum logic [2:0] {
      PH_ADDR_LO = 3'd0,
      PH_ADDR_HI = 3'd1,
      PH_LINK    = 3'd2,
      PH_LEN     = 3'd3,
      PH_TOKEN   = 3'd4,
      PH_TEXT    = 3'd5,
      PH_HALT    = 3'd6
   } phase_type;

   // Error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_TOKEN  = 2'd1;
   localparam logic [1:0] ERR_LENGTH = 2'd2;

   // Kinds of result a command may carry, in emission order
   localparam int KIND_TAB   = 0;
   localparam int KIND_M0    = 1;
   localparam int KIND_M1    = 2;
   localparam int KIND_M2    = 3;
   localparam int KIND_SPACE = 4;
   localparam int KIND_ETOK  = 5;
   localparam int KIND_CHAR  = 6;
   localparam int KIND_NL    = 7;
   localparam int KIND_FIN   = 8;
   localparam int KIND_COUNT = 9;

   // Work for the back end: one entry per input byte that causes output
   typedef struct packed {
      logic [KIND_COUNT-1:0] mask;
      logic [23:0]           m_chars;
      logic [7:0]            text_char;
      logic                  len_error;
   } cmd_type;

   // Queue status towards front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // Byte values
   localparam logic [7:0] TOK_NONE    = 8'h55;
   localparam logic [7:0] TOK_TAB_LIM = 8'h48;
   localparam logic [7:0] LEN_MIN     = 8'd3;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_RAISE    = 8'h60;
   localparam logic [7:0] CH_TAB      = 8'd9;
   localparam logic [7:0] CH_NL       = 8'd10;
   localparam logic [7:0] CH_NUL      = 8'd0;

   // Mnemonic table: three letters per token, first letter at the top
   localparam int MNEM_LEN = 255;
   localparam logic [8*MNEM_LEN-1:0] MNEM_STR = {
      "a11cpxcpyldxldystxsty",
      "aaxasrarraxsdcpdopisckillarlaxrlarraslosretop",
      "adcandaslbitbcsbeqbccbmibnebplbvsbvcbrk",
      "clccldcliclvcmpdecdexdeyeorincinxinyjmpjsrldalsrnopora",
      "phaphpplaplprolrorrtirtssbcsecsedseistataxtaytsxtxatxstya",
      ".la.ba.by.br.tx.md.de.ma.st.wa.on.wo.kc"
   };

   // Fetch the three letters of a token below TOK_NONE
   function automatic logic [23:0] mnem_chars(input logic [6:0] token);
      logic [7:0]  base;
      logic [10:0] pos;
      base = 8'(token) * 8'd3;
      pos  = 11'(8 * (MNEM_LEN - 3 - int'(base)));
      return MNEM_STR[pos +: 24];
   endfunction

endpackage

### hdl/tsd_front.sv
module tsd_front
   import tsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_type          req_item,
   output logic             req_stall,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_type          push_cmd
);

   phase_type  phase_ff, phase_in;
   logic [7:0] record_length_ff, record_length_in;
   logic [7:0] byte_position_ff, byte_position_in;
   logic       text_stopped_ff, text_stopped_in;

   phase_type  ph;
   logic [7:0] len;
   logic [7:0] pos;
   logic       stp;
   logic [7:0] b;
   logic       accept;
   cmd_type    cmd;

   // Hold the input while the queue is full
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign b         = req_item.data_byte;

   // Classify the byte and work out the next parser state
   always_comb begin
      ph  = req_item.file_start ? PH_ADDR_LO : phase_ff;
      len = req_item.file_start ? 8'd0 : record_length_ff;
      pos = req_item.file_start ? 8'd0 : byte_position_ff;
      stp = req_item.file_start ? 1'b0 : text_stopped_ff;

      phase_in         = ph;
      record_length_in = len;
      byte_position_in = pos;
      text_stopped_in  = stp;
      cmd              = '0;

      case (ph)
         PH_ADDR_LO: begin
            phase_in = PH_ADDR_HI;
         end
         PH_ADDR_HI: begin
            phase_in = PH_LINK;
         end
         PH_LINK: begin
            byte_position_in = 8'd1;
            text_stopped_in  = 1'b0;
            phase_in         = PH_LEN;
         end
         PH_LEN: begin
            if (b == 8'd0) begin
               cmd.mask[KIND_FIN] = 1'b1;
               phase_in           = PH_HALT;
            end else if (b < LEN_MIN) begin
               cmd.mask[KIND_FIN] = 1'b1;
               cmd.len_error      = 1'b1;
               phase_in           = PH_HALT;
            end else begin
               record_length_in = b;
               byte_position_in = 8'd2;
               phase_in         = PH_TOKEN;
            end
         end
         PH_TOKEN: begin
            if (b < TOK_NONE) begin
               cmd.mask[KIND_TAB]   = (b < TOK_TAB_LIM);
               cmd.mask[KIND_M0]    = 1'b1;
               cmd.mask[KIND_M1]    = 1'b1;
               cmd.mask[KIND_M2]    = 1'b1;
               cmd.mask[KIND_SPACE] = 1'b1;
               cmd.m_chars          = mnem_chars(b[6:0]);
            end else if (b > TOK_NONE) begin
               cmd.mask[KIND_ETOK] = 1'b1;
            end
            if (len <= LEN_MIN) begin
               cmd.mask[KIND_NL] = 1'b1;
               phase_in          = PH_LINK;
            end else begin
               byte_position_in = 8'd3;
               phase_in         = PH_TEXT;
            end
         end
         PH_TEXT: begin
            if (!stp) begin
               if (b == 8'd0) begin
                  text_stopped_in = 1'b1;
               end else begin
                  cmd.mask[KIND_CHAR] = 1'b1;
                  cmd.text_char       = (b < CH_SPACE) ? b + CH_RAISE : b;
               end
            end
            if (({1'b0, pos} + 9'd1) >= {1'b0, len}) begin
               cmd.mask[KIND_NL] = 1'b1;
               phase_in          = PH_LINK;
            end else begin
               byte_position_in = pos + 8'd1;
            end
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase
   end

   // Queue only bytes that cause output
   assign push     = accept && (cmd.mask != '0);
   assign push_cmd = cmd;

   // Advance the parser on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_ADDR_LO;
         record_length_ff <= 8'd0;
         byte_position_ff <= 8'd0;
         text_stopped_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         record_length_ff <= record_length_in;
         byte_position_ff <= byte_position_in;
         text_stopped_ff  <= text_stopped_in;
      end
   end

endmodule

### hdl/tsd_queue.sv
module tsd_queue
   import tsd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Wrap pointers at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd           = entry_ff[rd_ptr_ff];
   assign q_status.full      = (count_ff == CNT_W'(DEPTH));
   assign q_status.not_empty = (count_ff != '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_W'(DEPTH)))
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("command popped from an empty queue");

endmodule

### hdl/tsd_back.sv
module tsd_back
   import tsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          head_cmd,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   input  logic             rsp_stall
);

   logic [KIND_COUNT-1:0] done_ff, done_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_item_ff, rsp_item_in;

   logic [KIND_COUNT-1:0] remaining;
   logic [KIND_COUNT-1:0] sel;
   logic                  emit;
   logic                  is_last;

   // Pick the earliest kind still owed for the head command
   assign remaining = head_cmd.mask & ~done_ff;
   assign sel       = remaining & (~remaining + 1'b1);
   assign is_last   = (remaining == sel);
   assign emit      = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign pop       = emit && is_last;
   assign done_in   = pop ? '0 : (done_ff | sel);

   // Build the result item for the selected kind
   always_comb begin
      rsp_item_in          = '0;
      rsp_item_in.last     = is_last;
      rsp_item_in.out_char = CH_NUL;
      rsp_item_in.error    = ERR_NONE;
      if (sel[KIND_TAB]) begin
         rsp_item_in.out_char = CH_TAB;
      end else if (sel[KIND_M0]) begin
         rsp_item_in.out_char = head_cmd.m_chars[23:16];
      end else if (sel[KIND_M1]) begin
         rsp_item_in.out_char = head_cmd.m_chars[15:8];
      end else if (sel[KIND_M2]) begin
         rsp_item_in.out_char = head_cmd.m_chars[7:0];
      end else if (sel[KIND_SPACE]) begin
         rsp_item_in.out_char = CH_SPACE;
      end else if (sel[KIND_ETOK]) begin
         rsp_item_in.error = ERR_TOKEN;
      end else if (sel[KIND_CHAR]) begin
         rsp_item_in.out_char = head_cmd.text_char;
      end else if (sel[KIND_NL]) begin
         rsp_item_in.out_char = CH_NL;
      end else if (sel[KIND_FIN]) begin
         rsp_item_in.finished = 1'b1;
         rsp_item_in.error    = head_cmd.len_error ? ERR_LENGTH : ERR_NONE;
      end
   end

   // Track progress through the head command
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else if (emit) begin
         done_ff <= done_in;
      end
   end

   // Output register: load on emit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_work_owed: assert property (@(posedge clock) disable iff (reset)
      emit |-> (remaining != '0))
      else $error("head command has nothing left to emit");

   a_finish_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.finished) |-> rsp_item_ff.last)
      else $error("finish marker is not the final item of its byte");

endmodule

### hdl/tokenized_source_detokenizer.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_item  (data_byte, file_start)
// rsp_      out        rsp_valid/rsp_stall   rsp_item  (out_char, last, finished, error)
//
// A byte is taken in the cycle it is offered while the command queue has room; its first
// result passes through the command queue and is then loaded into the output register.
// A byte causing k results (up to six) sends them from the output register one after another,
// and the command queue of QUEUE_DEPTH entries lets following bytes be taken meanwhile.
// Reset is synchronous: parser to the load address, queue emptied, pending item dropped.
// req_stall rises only while the queue is full; rsp_stall holds a valid item in the output register.
module tokenized_source_detokenizer
   import tsd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_item,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_item,
   input  logic    rsp_stall
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;

   tsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   tsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   tsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall)
   );

endmodule

### tb/sv/detok_checker.sv
`timescale 1ns / 100ps

module detok_checker
   import tsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_item,
   input  logic    req_stall,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   input  logic    rsp_stall,
   output int      mismatch_count,
   output int      chars_due
);

   // Three letters per token, token 0 first
   string mnemonics = {
      "a11cpxcpyldxldystxsty",
      "aaxasrarraxsdcpdopisckillarlaxrlarraslosretop",
      "adcandaslbitbcsbeqbccbmibnebplbvsbvcbrk",
      "clccldcliclvcmpdecdexdeyeorincinxinyjmpjsrldalsrnopora",
      "phaphpplaplprolrorrtirtssbcsecsedseistataxtaytsxtxatxstya",
      ".la.ba.by.br.tx.md.de.ma.st.wa.on.wo.kc"
   };

   rsp_type    expected_chars[$];
   phase_type  phase;
   logic [7:0] rec_len;
   logic [7:0] byte_pos;
   logic       text_stop;

   function automatic rsp_type make_char(input logic [7:0] ch, input logic fin,
                                         input logic [1:0] err);
      rsp_type r;
      r.out_char = ch;
      r.last     = 1'b0;
      r.finished = fin;
      r.error    = err;
      return r;
   endfunction

   // Advance the parser by one byte and queue the characters it yields
   function automatic void expand_byte(input req_type it);
      rsp_type    batch[$];
      rsp_type    r;
      logic [7:0] b;
      int         k;
      b = it.data_byte;
      if (it.file_start) begin
         phase     = PH_ADDR_LO;
         rec_len   = 8'd0;
         byte_pos  = 8'd0;
         text_stop = 1'b0;
      end
      case (phase)
         PH_ADDR_LO: phase = PH_ADDR_HI;
         PH_ADDR_HI: phase = PH_LINK;
         PH_LINK: begin
            byte_pos  = 8'd1;
            text_stop = 1'b0;
            phase     = PH_LEN;
         end
         PH_LEN: begin
            if (b == 8'd0) begin
               batch.push_back(make_char(CH_NUL, 1'b1, ERR_NONE));
               phase = PH_HALT;
            end else if (b < LEN_MIN) begin
               batch.push_back(make_char(CH_NUL, 1'b1, ERR_LENGTH));
               phase = PH_HALT;
            end else begin
               rec_len  = b;
               byte_pos = 8'd2;
               phase    = PH_TOKEN;
            end
         end
         PH_TOKEN: begin
            if (b < TOK_NONE) begin
               if (b < TOK_TAB_LIM) batch.push_back(make_char(CH_TAB, 1'b0, ERR_NONE));
               for (k = 0; k < 3; k++)
                  batch.push_back(make_char(mnemonics[int'(b) * 3 + k], 1'b0, ERR_NONE));
               batch.push_back(make_char(CH_SPACE, 1'b0, ERR_NONE));
            end else if (b > TOK_NONE) begin
               batch.push_back(make_char(CH_NUL, 1'b0, ERR_TOKEN));
            end
            // a record of length three carries no text
            if (rec_len <= LEN_MIN) begin
               batch.push_back(make_char(CH_NL, 1'b0, ERR_NONE));
               phase = PH_LINK;
            end else begin
               byte_pos = 8'd3;
               phase    = PH_TEXT;
            end
         end
         PH_TEXT: begin
            if (!text_stop) begin
               if (b == 8'd0)
                  text_stop = 1'b1;
               else
                  batch.push_back(make_char((b < CH_SPACE) ? b + CH_RAISE : b,
                                            1'b0, ERR_NONE));
            end
            if (9'(byte_pos) + 9'd1 >= 9'(rec_len)) begin
               batch.push_back(make_char(CH_NL, 1'b0, ERR_NONE));
               phase = PH_LINK;
            end else begin
               byte_pos = byte_pos + 8'd1;
            end
         end
         default: phase = PH_HALT;
      endcase
      // mark the final character of the byte
      for (k = 0; k < batch.size(); k++) begin
         r      = batch[k];
         r.last = (k == batch.size() - 1);
         expected_chars.push_back(r);
      end
   endfunction

   initial begin
      mismatch_count = 0;
      chars_due      = 0;
      phase          = PH_ADDR_LO;
      rec_len        = 8'd0;
      byte_pos       = 8'd0;
      text_stop      = 1'b0;
   end

   // Check outgoing items first, then predict from the incoming one
   always @(posedge clock) begin
      rsp_type exp_char;
      if (reset) begin
         phase     = PH_ADDR_LO;
         rec_len   = 8'd0;
         byte_pos  = 8'd0;
         text_stop = 1'b0;
         expected_chars.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected item, got char %02h last %b fin %b err %0d",
                        $time, rsp_item.out_char, rsp_item.last, rsp_item.finished,
                        rsp_item.error);
               mismatch_count = mismatch_count + 1;
            end else begin
               exp_char = expected_chars.pop_front();
               if (rsp_item.out_char !== exp_char.out_char ||
                   rsp_item.last !== exp_char.last ||
                   rsp_item.finished !== exp_char.finished ||
                   rsp_item.error !== exp_char.error) begin
                  $display("%0t: mismatch, expected char %02h last %b fin %b err %0d",
                           $time, exp_char.out_char, exp_char.last, exp_char.finished,
                           exp_char.error);
                  $display("%0t:           got char %02h last %b fin %b err %0d",
                           $time, rsp_item.out_char, rsp_item.last, rsp_item.finished,
                           rsp_item.error);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) expand_byte(req_item);
      end
      chars_due = expected_chars.size();
   end

endmodule

### tb/sv/tokenized_source_detokenizer_tb.sv
`timescale 1ns / 100ps

module tokenized_source_detokenizer_tb
   import tsd_pkg::*;
();

   logic    clock;
   logic    reset;
   logic    req_valid;
   req_type req_item;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    rsp_stall;
   int      mismatch_count;
   int      chars_due;

   int      bytes_sent;
   bit      quiet;

   tokenized_source_detokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall)
   );

   detok_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_item       (req_item),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .rsp_stall      (rsp_stall),
      .mismatch_count (mismatch_count),
      .chars_due      (chars_due)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Offer one byte after a random gap, none in quiet files, and hold it until taken
   task automatic send_byte(input logic [7:0] d, input logic fs);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_item.data_byte  <= d;
      req_item.file_start <= fs;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (chars_due != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] text_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'($urandom_range(1, 31));
         2:       return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Send one file: mostly well-formed records, sometimes broken or cut short
   task automatic send_random_file();
      int         kind, nrec, r, k, len, cut;
      logic [7:0] tok;
      kind  = $urandom_range(0, 9);
      nrec  = $urandom_range(1, 4);
      quiet = ($urandom_range(0, 3) == 0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      for (r = 0; r < nrec; r++) begin
         len = ($urandom_range(0, 11) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
         tok = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 84))
                                           : 8'($urandom_range(0, 255));
         cut = (kind == 8 && r == nrec - 1) ? $urandom_range(0, len - 1) : len;
         send_byte(8'($urandom_range(0, 255)), 1'b0);
         if (cut > 1) send_byte(8'(len), 1'b0);
         if (cut > 2) send_byte(tok, 1'b0);
         for (k = 3; k < cut; k++) send_byte(text_byte(), 1'b0);
      end
      if (kind == 8) return;
      // close the file, then feed bytes the parser must ignore
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte((kind == 7) ? 8'($urandom_range(1, 2)) : 8'h00, 1'b0);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // Receiver: random stall per item, quiet stretches, one long hold-off
   initial begin : rsp_side
      int n, taken;
      bit burst;
      rsp_stall = 1'b0;
      taken     = 0;
      burst     = 1'b0;
      forever begin
         if (taken % 16 == 0) burst = ($urandom_range(0, 2) == 0);
         n = (taken == 30) ? 200 : (burst ? 0 : $urandom_range(0, 13));
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (reset || !rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : timeout
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int file_no;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      bytes_sent = 0;
      quiet      = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed file: tab and no-tab tokens, raised and high text bytes,
      // zero text byte, no mnemonic, token out of range, bare record, end record
      send_byte(8'h01, 1'b1);
      send_byte(8'h08, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h06, 1'b0);
      send_byte(8'h47, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h48, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h12, 1'b0);
      // restart mid-stream and hit a malformed length
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);

      file_no = 0;
      while (bytes_sent < 130) begin
         send_random_file();
         file_no++;
         if (file_no == 2) wait_drained();
      end

      // Drain, then allow the pipeline to settle
      wait_drained();
      repeat (24) @(negedge clock);
      if (mismatch_count == 0 && chars_due == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
